// ----- rtl/ptsb_pkg.sv -----
`default_nettype none

package ptsb_pkg;

  // Default bank size and the cap on expiry results per tick.
  localparam int DEFAULT_NUM_SLOTS = 16;
  localparam int MAX_RESULTS       = 16;

  // Command codes on the cmd input.
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_ALLOC   = 3'd1;
  localparam logic [2:0] CMD_ENABLE  = 3'd2;
  localparam logic [2:0] CMD_DISABLE = 3'd3;
  localparam logic [2:0] CMD_FREE    = 3'd4;

  // Result kinds on the kind output.
  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_GRANTED = 3'd1;
  localparam logic [2:0] KIND_FULL    = 3'd2;
  localparam logic [2:0] KIND_EXPIRY  = 3'd3;
  localparam logic [2:0] KIND_IDLE    = 3'd4;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_FLUSH,
    ST_SCAN,
    ST_EN_RD,
    ST_EN_WR,
    ST_REPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // a transaction is accepted; latch its fields
    logic tick_run;  // sweep the slots for a tick
    logic flush;     // give the final tick result
    logic scan;      // search for a free slot
    logic en_wr;     // write the reloaded count for enable
    logic reply;     // disable, free or unused code, with an ack
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/ptsb_ctrl.sv -----
`default_nettype none

module ptsb_ctrl
  import ptsb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [2:0] cmd,
  input  wire dp_status_t status,
  output      ctl_cmd_t   ctl,
  output      logic       busy
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_TICK:   state_next = ST_TICK;
            CMD_ALLOC:  state_next = ST_SCAN;
            CMD_ENABLE: state_next = ST_EN_RD;
            default:    state_next = ST_REPLY;
          endcase
        end
      end
      ST_TICK: begin
        if (status.sweep_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_EN_RD: state_next = ST_EN_WR;
      ST_FLUSH, ST_EN_WR, ST_REPLY: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      ST_TICK:  ctl.tick_run = 1'b1;
      ST_FLUSH: ctl.flush    = 1'b1;
      ST_SCAN:  ctl.scan     = 1'b1;
      ST_EN_RD: ctl          = '0;
      ST_EN_WR: ctl.en_wr    = 1'b1;
      ST_REPLY: ctl.reply    = 1'b1;
      default:  ctl          = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ptsb_datapath.sv -----
`default_nettype none

module ptsb_datapath
  import ptsb_pkg::*;
#(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ctl_cmd_t   ctl,
  input  wire logic [2:0] cmd,
  input  wire logic [3:0] slot_index,
  input  wire logic [7:0] reload_value,
  input  wire logic       has_handler,
  output      dp_status_t status,
  output      logic       strobe,
  output      logic [2:0] kind,
  output      logic [3:0] slot_out,
  output      logic       last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(NUM_SLOTS);
  localparam logic [4:0] RES_CAP = 5'(MAX_RESULTS);

  // Low four bits of a slot number, for the result port.
  function automatic logic [3:0] low4(input logic [IDX_W-1:0] s);
    logic [IDX_W+3:0] w;
    w = (IDX_W + 4)'(s);
    return w[3:0];
  endfunction

  // Latched fields of the current transaction.
  logic [2:0] op;
  logic [3:0] idx_q;
  logic [7:0] reload_q;
  logic       handler_q;

  // Per-slot flags; valid marks period and count entries that hold data.
  logic [NUM_SLOTS-1:0] in_use;
  logic [NUM_SLOTS-1:0] armed;
  logic [NUM_SLOTS-1:0] notify;
  logic [NUM_SLOTS-1:0] valid;

  // Period and count memories with registered reads.
  logic [7:0] period_mem [NUM_SLOTS];
  logic [7:0] count_mem  [NUM_SLOTS];
  logic [7:0] rd_period;
  logic [7:0] rd_count;

  // Sweep pointer, read stage and pending expiry.
  logic [CNT_W-1:0] ptr;
  logic             s1_vld;
  logic [IDX_W-1:0] s1_idx;
  logic             pend_vld;
  logic [IDX_W-1:0] pend_idx;
  logic [4:0]       reported;

  logic [IDX_W-1:0] ptr_idx;
  logic [IDX_W+3:0] idx_wide;
  logic [IDX_W-1:0] sel_idx;
  logic             in_range;
  logic             issue;
  logic [7:0]       cur_cnt;
  logic [7:0]       cur_per;
  logic             tick_act;
  logic             tick_exp;
  logic             scan_hit;
  logic             scan_end;
  logic [IDX_W-1:0] rd_addr;
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr;
  logic [7:0]       cnt_wdata;
  logic             per_we;

  // Address decode and the per-slot tick decision.
  always_comb begin
    ptr_idx  = ptr[IDX_W-1:0];
    idx_wide = (IDX_W + 4)'(idx_q);
    sel_idx  = idx_wide[IDX_W-1:0];
    in_range = 32'(idx_q) < NUM_SLOTS;
    issue    = ptr != SLOT_END;
    cur_cnt  = valid[s1_idx] ? rd_count : 8'd0;
    cur_per  = valid[s1_idx] ? rd_period : 8'd0;
    tick_act = ctl.tick_run & s1_vld & armed[s1_idx];
    tick_exp = tick_act & (cur_cnt == 8'd0) & notify[s1_idx] & (reported < RES_CAP);
    scan_hit = issue & ~in_use[ptr_idx];
    scan_end = ~issue;
    rd_addr  = ctl.tick_run ? ptr_idx : sel_idx;
    status.sweep_done = ~issue & ~s1_vld;
    status.scan_done  = scan_hit | scan_end;
  end

  // Write port selection for the memories.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = sel_idx;
    cnt_wdata = 8'd0;
    per_we    = 1'b0;
    if (tick_act) begin
      cnt_we    = 1'b1;
      cnt_waddr = s1_idx;
      cnt_wdata = (cur_cnt != 8'd0) ? cur_cnt - 8'd1 : cur_per;
    end else if (ctl.scan && scan_hit) begin
      cnt_we    = 1'b1;
      per_we    = 1'b1;
      cnt_waddr = ptr_idx;
      cnt_wdata = reload_q;
    end else if (ctl.en_wr && in_range) begin
      cnt_we    = 1'b1;
      cnt_wdata = valid[sel_idx] ? rd_period : 8'd0;
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    if (per_we) begin
      period_mem[cnt_waddr] <= cnt_wdata;
    end
    rd_count  <= count_mem[rd_addr];
    rd_period <= period_mem[rd_addr];
  end

  // Transaction fields.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op        <= cmd;
      idx_q     <= slot_index;
      reload_q  <= reload_value;
      handler_q <= has_handler;
    end
  end

  // Flags, sweep control and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use   <= '0;
      armed    <= '0;
      notify   <= '0;
      valid    <= '0;
      ptr      <= '0;
      s1_vld   <= 1'b0;
      pend_vld <= 1'b0;
      reported <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;

      if (ctl.load) begin
        ptr      <= '0;
        s1_vld   <= 1'b0;
        pend_vld <= 1'b0;
        reported <= '0;
      end

      // Tick sweep: one slot read per cycle, processed in the next.
      if (ctl.tick_run) begin
        if (issue) begin
          ptr <= ptr + CNT_W'(1);
        end
        s1_vld <= issue;
        s1_idx <= ptr_idx;
        if (tick_exp) begin
          if (pend_vld) begin
            strobe   <= 1'b1;
            kind     <= KIND_EXPIRY;
            slot_out <= low4(pend_idx);
            last     <= 1'b0;
          end
          pend_vld <= 1'b1;
          pend_idx <= s1_idx;
          reported <= reported + 5'd1;
        end
      end

      // Final tick result.
      if (ctl.flush) begin
        strobe   <= 1'b1;
        last     <= 1'b1;
        kind     <= pend_vld ? KIND_EXPIRY : KIND_IDLE;
        slot_out <= pend_vld ? low4(pend_idx) : 4'd0;
      end

      // Free slot search for alloc.
      if (ctl.scan) begin
        if (scan_hit) begin
          in_use[ptr_idx] <= 1'b1;
          armed[ptr_idx]  <= 1'b0;
          notify[ptr_idx] <= handler_q;
          valid[ptr_idx]  <= 1'b1;
          strobe          <= 1'b1;
          kind            <= KIND_GRANTED;
          slot_out        <= low4(ptr_idx);
          last            <= 1'b1;
        end else if (scan_end) begin
          strobe   <= 1'b1;
          kind     <= KIND_FULL;
          slot_out <= 4'd0;
          last     <= 1'b1;
        end else begin
          ptr <= ptr + CNT_W'(1);
        end
      end

      // Enable arms the slot; the count is written from the period as well.
      if (ctl.en_wr) begin
        if (in_range) begin
          armed[sel_idx] <= 1'b1;
        end
        strobe   <= 1'b1;
        kind     <= KIND_ACK;
        slot_out <= 4'd0;
        last     <= 1'b1;
      end

      // Disable, free and unused codes.
      if (ctl.reply) begin
        if (in_range) begin
          case (op)
            CMD_DISABLE: armed[sel_idx] <= 1'b0;
            CMD_FREE: begin
              armed[sel_idx]  <= 1'b0;
              in_use[sel_idx] <= 1'b0;
              notify[sel_idx] <= 1'b0;
              valid[sel_idx]  <= 1'b0;
            end
            default: ;
          endcase
        end
        strobe   <= 1'b1;
        kind     <= KIND_ACK;
        slot_out <= 4'd0;
        last     <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/periodic_timer_slot_bank.sv -----
`default_nettype none

// Bank of periodic down-counting timer slots.
// A transaction is taken at a rising edge with start high and busy low; cmd selects
// tick, alloc, enable, disable or free, with slot_index, reload_value and has_handler.
// Each result sits on kind, slot_out and last for one cycle, marked by strobe; the
// receiver cannot stall, so results are never held back. last marks the final
// result of a transaction.
// A tick sweeps the period and count memories one slot per cycle; its expiry
// results stream out during the sweep in ascending slot order, the last one
// (or a single no-expiry result) at the end.
// Alloc checks one slot per cycle from slot 0 and stops at the lowest free slot,
// or after the last slot when the bank is full. Enable passes through a read
// state and a write state because of the registered memory read; disable, free
// and unused codes go through a reply state. The final result shows in the first
// cycle that busy is low again, when a new transaction can already be taken.
// Reset clears all slot flags and marks every memory entry as zero, so no
// clearing pass is needed.
module periodic_timer_slot_bank
  import ptsb_pkg::*;
#(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output      logic       busy,
  input  wire logic [2:0] cmd,
  input  wire logic [3:0] slot_index,
  input  wire logic [7:0] reload_value,
  input  wire logic       has_handler,
  output      logic       strobe,
  output      logic [2:0] kind,
  output      logic [3:0] slot_out,
  output      logic       last
);

  ctl_cmd_t   ctl;
  dp_status_t status;

  // Sequencer.
  ptsb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .status (status),
    .ctl    (ctl),
    .busy   (busy)
  );

  // Slot state, memories and result register.
  ptsb_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cmd          (cmd),
    .slot_index   (slot_index),
    .reload_value (reload_value),
    .has_handler  (has_handler),
    .status       (status),
    .strobe       (strobe),
    .kind         (kind),
    .slot_out     (slot_out),
    .last         (last)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptsb_pkg::*;

  localparam int NSLOT        = DEFAULT_NUM_SLOTS;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = NSLOT + 8;
  localparam int RANDOM_ITEMS = 500;

  // Command codes the block does not define; they must be acknowledged and ignored.
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic       last;
  } timer_result_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       start        = 1'b0;
  logic [2:0] cmd          = CMD_TICK;
  logic [3:0] slot_index   = 4'd0;
  logic [7:0] reload_value = 8'd0;
  logic       has_handler  = 1'b0;
  wire        busy;
  wire        strobe;
  wire  [2:0] kind;
  wire  [3:0] slot_out;
  wire        last;

  periodic_timer_slot_bank #(.NUM_SLOTS(NSLOT)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .slot_index   (slot_index),
    .reload_value (reload_value),
    .has_handler  (has_handler),
    .strobe       (strobe),
    .kind         (kind),
    .slot_out     (slot_out),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the slot table, kept in step with every accepted transaction.
  logic       slot_used    [NSLOT] = '{default: 1'b0};
  logic       slot_live    [NSLOT] = '{default: 1'b0};
  logic       slot_reports [NSLOT] = '{default: 1'b0};
  logic [7:0] slot_reload  [NSLOT] = '{default: 8'd0};
  logic [7:0] slot_left    [NSLOT] = '{default: 8'd0};

  timer_result_t pending_results[$];
  int            error_count = 0;
  int            items_sent  = 0;
  bit            no_gaps     = 1'b0;

  function automatic void push_result(logic [2:0] k, logic [3:0] s, logic l);
    timer_result_t r;
    r.kind = k;
    r.slot = s;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  // Update the shadow table for one transaction and queue the results it must give.
  function automatic void predict_timer_cmd(logic [2:0] c, logic [3:0] idx,
                                            logic [7:0] rv, logic h);
    int  n;
    bit  granted;
    n = 0;
    granted = 1'b0;
    case (c)
      CMD_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_live[i]) begin
            if (slot_left[i] != 8'd0) begin
              slot_left[i] = slot_left[i] - 8'd1;
            end else begin
              slot_left[i] = slot_reload[i];
              if (slot_reports[i] && n < MAX_RESULTS) begin
                push_result(KIND_EXPIRY, 4'(i), 1'b0);
                n++;
              end
            end
          end
        end
        if (n == 0) begin
          push_result(KIND_IDLE, 4'd0, 1'b1);
        end else begin
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
      end
      CMD_ALLOC: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!granted && !slot_used[i]) begin
            slot_live[i]    = 1'b0;
            slot_reports[i] = h;
            slot_reload[i]  = rv;
            slot_left[i]    = rv;
            slot_used[i]    = 1'b1;
            granted         = 1'b1;
            push_result(KIND_GRANTED, 4'(i), 1'b1);
          end
        end
        if (!granted) push_result(KIND_FULL, 4'd0, 1'b1);
      end
      CMD_ENABLE: begin
        if (idx < NSLOT) begin
          slot_left[idx] = slot_reload[idx];
          slot_live[idx] = 1'b1;
        end
        push_result(KIND_ACK, 4'd0, 1'b1);
      end
      CMD_DISABLE: begin
        if (idx < NSLOT) slot_live[idx] = 1'b0;
        push_result(KIND_ACK, 4'd0, 1'b1);
      end
      CMD_FREE: begin
        if (idx < NSLOT) begin
          slot_live[idx]    = 1'b0;
          slot_used[idx]    = 1'b0;
          slot_reports[idx] = 1'b0;
          slot_reload[idx]  = 8'd0;
          slot_left[idx]    = 8'd0;
        end
        push_result(KIND_ACK, 4'd0, 1'b1);
      end
      default: begin
        push_result(KIND_ACK, 4'd0, 1'b1);
      end
    endcase
  endfunction

  // Lowest slot not in use, or -1 when the bank is full.
  function automatic int lowest_free_slot();
    int found;
    found = -1;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (!slot_used[i]) found = i;
    end
    return found;
  endfunction

  // Mostly a slot that is in use, sometimes any slot at all.
  function automatic logic [3:0] pick_slot();
    int used_list[$];
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_used[i]) used_list.push_back(i);
    end
    if (used_list.size() != 0 && $urandom_range(0, 9) < 7) begin
      return 4'(used_list[$urandom_range(0, used_list.size() - 1)]);
    end
    return 4'($urandom_range(0, NSLOT - 1));
  endfunction

  function automatic logic [7:0] pick_reload();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 4));
  endfunction

  // Drive one transaction after a random gap and wait until the block takes it.
  task automatic send_cmd(input logic [2:0] c, input logic [3:0] idx,
                          input logic [7:0] rv, input logic h);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= c;
    slot_index   <= idx;
    reload_value <= rv;
    has_handler  <= h;
    do @(posedge clk); while (busy);
    predict_timer_cmd(c, idx, rv, h);
    items_sent++;
  endtask

  // Empty bank: ticks with nothing armed, and a slot armed without being allocated.
  task automatic test_empty_bank();
    send_cmd(CMD_TICK, 4'hF, 8'hFF, 1'b1);
    send_cmd(CMD_ENABLE, 4'd3, 8'($urandom), 1'($urandom));
    send_cmd(CMD_TICK, 4'd0, 8'd0, 1'b0);
    send_cmd(CMD_TICK, 4'($urandom), 8'($urandom), 1'($urandom));
    send_cmd(CMD_DISABLE, 4'd3, 8'd0, 1'b0);
    send_cmd(CMD_FREE, 4'd3, 8'hFF, 1'b1);
  endtask

  // Fill every slot, with the reload extremes, then ask once more for a full bank.
  task automatic test_alloc_until_full();
    logic [7:0] rv;
    for (int i = 0; i < NSLOT; i++) begin
      rv = (i == 0) ? 8'd0 : (i == 1) ? 8'hFF : pick_reload();
      send_cmd(CMD_ALLOC, 4'($urandom), rv, 1'(i % 3 != 1));
    end
    send_cmd(CMD_ALLOC, 4'hF, 8'hFF, 1'b1);
  endtask

  task automatic test_spare_codes();
    send_cmd(CMD_SPARE_5, 4'hF, 8'hFF, 1'b1);
    send_cmd(CMD_SPARE_6, 4'd0, 8'd0, 1'b0);
    send_cmd(CMD_SPARE_7, 4'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Every slot reports on the same tick, which gives the longest burst of results.
  task automatic test_all_slots_expire();
    for (int i = 0; i < NSLOT; i++) send_cmd(CMD_FREE, 4'(i), 8'($urandom), 1'($urandom));
    for (int i = 0; i < NSLOT; i++) send_cmd(CMD_ALLOC, 4'($urandom), 8'd0, 1'b1);
    for (int i = 0; i < NSLOT; i++) send_cmd(CMD_ENABLE, 4'(i), 8'($urandom), 1'($urandom));
    repeat (3) send_cmd(CMD_TICK, 4'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Random mix of single commands and alloc, enable, tick sequences.
  task automatic test_random_mix(input int count);
    int         target;
    int         sel;
    int         free_slot;
    logic [7:0] rv;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 39) == 0) no_gaps = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        free_slot = lowest_free_slot();
        rv = 8'($urandom_range(0, 3));
        send_cmd(CMD_ALLOC, 4'($urandom), rv, 1'($urandom_range(0, 4) != 0));
        if (free_slot >= 0) begin
          send_cmd(CMD_ENABLE, 4'(free_slot), 8'($urandom), 1'($urandom));
          repeat ($urandom_range(1, rv + 3)) begin
            send_cmd(CMD_TICK, 4'($urandom), 8'($urandom), 1'($urandom));
          end
        end
      end else if (sel < 40) begin
        send_cmd(CMD_TICK, 4'($urandom), 8'($urandom), 1'($urandom));
      end else if (sel < 58) begin
        send_cmd(CMD_ALLOC, 4'($urandom), pick_reload(), 1'($urandom_range(0, 3) != 0));
      end else if (sel < 72) begin
        send_cmd(CMD_ENABLE, pick_slot(), 8'($urandom), 1'($urandom));
      end else if (sel < 80) begin
        send_cmd(CMD_DISABLE, pick_slot(), 8'($urandom), 1'($urandom));
      end else if (sel < 93) begin
        send_cmd(CMD_FREE, pick_slot(), 8'($urandom), 1'($urandom));
      end else begin
        send_cmd(3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7)), 4'($urandom),
                 8'($urandom), 1'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  // Compare each strobed result with the oldest expected one.
  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d slot_out %0d last %0d", kind, slot_out, last);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          error_count++;
        end
        if (slot_out !== want.slot) begin
          $error("slot_out: expected %0d, actual %0d", want.slot, slot_out);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no transaction and no result.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_bank();
    test_alloc_until_full();
    test_spare_codes();
    test_all_slots_expire();
    test_random_mix(RANDOM_ITEMS);

    // Let the last transaction finish and make sure nothing else comes out.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
